// ----- src/rte_pkg.sv -----
`default_nettype none

package rte_pkg;

    // Fixed field widths
    localparam int COORD_W   = 23;
    localparam int EDGE_W    = 24;
    localparam int IDX_W     = 10;
    localparam int TAG_W     = 5;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int LIMIT_W   = 11;

    // Request codes
    localparam logic [1:0] REQ_RESTART = 2'd0;
    localparam logic [1:0] REQ_GOAL    = 2'd1;
    localparam logic [1:0] REQ_OCC     = 2'd2;
    localparam logic [1:0] REQ_SAMPLE  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SAMPLE_BLOCKED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STEP_BLOCKED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL           = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_CAND        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WRITE_DONE     = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COUNT  = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [6:0]         slot_index;
        logic               word_half;
        logic [63:0]        occupancy_word;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    node_index;
        logic [IDX_W-1:0]    parent_index;
        logic [COORD_W-1:0]  node_x;
        logic [COORD_W-1:0]  node_y;
        logic [TAG_W-1:0]    goal_hit;
        logic [EDGE_W-1:0]   edge_length;
    } result_t;

    // |a - b| on coordinates
    function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// ----- src/rte_sqrt.sv -----
`default_nettype none

module rte_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] radicand,
    output logic             done,
    output logic [23:0]      root
);

    logic [47:0] rad_reg;
    logic [24:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [26:0] cur;
    logic [26:0] trial;
    logic        ge;

    // One result bit per cycle, two radicand bits consumed
    assign cur   = {rem_reg, rad_reg[47:46]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[45:0], 2'b00};
            rem_reg  <= ge ? 25'(cur - trial) : cur[24:0];
            root_reg <= {root_reg[22:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- src/rte_div.sv -----
`default_nettype none

module rte_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] num,
    input  wire logic [23:0] den,
    output logic             done,
    output logic [47:0]      quot
);

    logic [47:0] q_reg;
    logic [23:0] rem_reg;
    logic [23:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [24:0] shifted;
    logic        ge;

    // Restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, q_reg[47]};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? 24'(shifted - {1'b0, den_reg}) : shifted[23:0];
            q_reg   <= {q_reg[46:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ----- src/rrt_tree_extend.sv -----
`default_nettype none

// Tree extender for sampling-based planning. One request is taken when start is
// high and busy is low; its single result appears on result for exactly one
// cycle with result_valid high and cannot be held off. Restart, goal and
// occupancy writes, and samples refused as full, answer in the cycle after
// acceptance; a sample blocked at its own cell answers from the cell read or
// cell check state. The nearest-node scan uses the shared multiplier in an X
// and a Y state per node, then a 24-step square root and, when the sample lies
// beyond the radius, two 48-step divisions finish the steering. The occupancy
// grid is cleared at reset through per-word valid bits, so no clearing pass is
// needed.
module rrt_tree_extend #(
    parameter int MAX_NODES  = 1024,
    parameter int MAX_GOALS  = 16,
    parameter int GRID_CELLS = 100,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cfg_we,
    input  wire logic [rte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rte_pkg::COORD_W-1:0]   cfg_data,
    input  wire rte_pkg::req_t                 req,
    output rte_pkg::result_t                   result,
    output logic                               result_valid
);

    import rte_pkg::*;

    localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SW  = $clog2(MAX_NODES + 1);
    localparam int LW  = (SW > LIMIT_W) ? SW : LIMIT_W;
    localparam int GW  = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;
    localparam int GCW = $clog2(MAX_GOALS + 1);
    localparam int AW  = $clog2(2 * GRID_CELLS);
    localparam logic [COORD_W-1:0] RADIUS_RST = COORD_W'(64'd5 << FRAC_BITS);

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_CELL_RD  = 16'b0000_0000_0000_0010,
        S_CELL_CHK = 16'b0000_0000_0000_0100,
        S_SCAN_RD  = 16'b0000_0000_0000_1000,
        S_SCAN_X   = 16'b0000_0000_0001_0000,
        S_SCAN_Y   = 16'b0000_0000_0010_0000,
        S_POST     = 16'b0000_0000_0100_0000,
        S_SQRT     = 16'b0000_0000_1000_0000,
        S_MUL_X    = 16'b0000_0001_0000_0000,
        S_DIV_X    = 16'b0000_0010_0000_0000,
        S_MUL_Y    = 16'b0000_0100_0000_0000,
        S_DIV_Y    = 16'b0000_1000_0000_0000,
        S_GOAL_RD  = 16'b0001_0000_0000_0000,
        S_GOAL_X   = 16'b0010_0000_0000_0000,
        S_GOAL_Y   = 16'b0100_0000_0000_0000,
        S_STORE    = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration and control state
    logic [COORD_W-1:0] origin_x_reg, origin_y_reg, radius_reg;
    logic [LIMIT_W-1:0] node_limit_reg;
    logic [4:0]         goal_count_reg;
    logic [SW-1:0]      tree_size_reg;
    logic [COORD_W-1:0] root_x_reg, root_y_reg;
    logic [2*GRID_CELLS-1:0] grid_vld_reg;
    logic               gvld_q;
    logic               result_valid_reg;

    // Datapath registers
    logic [COORD_W-1:0] px_reg, py_reg, chk_x_reg, chk_y_reg;
    logic [45:0]        r2_reg;
    logic               phase_reg;
    logic [SW-1:0]      scan_i_reg;
    logic [GCW-1:0]     gi_reg;
    logic [47:0]        prod_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [COORD_W-1:0] cur_x_reg, cur_y_reg;
    logic               cur_tag_reg;
    logic               found_reg;
    logic [46:0]        best_d_reg;
    logic [SW-1:0]      best_i_reg;
    logic [COORD_W-1:0] bx_reg, by_reg;
    logic [23:0]        s_reg;
    logic [COORD_W-1:0] dxb_reg;
    logic [COORD_W-1:0] nx_reg;
    logic [EDGE_W-1:0]  edge_reg;
    logic [8:0]         tag_reg;
    result_t            result_reg;

    // Memories
    logic [COORD_W-1:0] tree_x_mem [MAX_NODES];
    logic [COORD_W-1:0] tree_y_mem [MAX_NODES];
    logic               tree_t_mem [MAX_NODES];
    logic [COORD_W-1:0] goal_x_mem [MAX_GOALS];
    logic [COORD_W-1:0] goal_y_mem [MAX_GOALS];
    logic [63:0]        grid_mem   [2*GRID_CELLS];
    logic [COORD_W-1:0] tx_q, ty_q, gx_q, gy_q;
    logic               tt_q, tzero_q;
    logic [63:0]        grid_q;

    // Combinational signals
    logic               accept;
    logic [LW-1:0]      limit;
    logic [GCW-1:0]     goals;
    logic [31:0]        ri32, ci32;
    logic               outside, blocked;
    logic [AW-1:0]      grid_ra, grid_wa;
    logic               grid_we;
    logic [SW-1:0]      nxt_i;
    logic [NW-1:0]      tree_ra;
    logic [GCW-1:0]     gnext;
    logic [GW-1:0]      goal_ra;
    logic [COORD_W-1:0] tx, ty;
    logic               ttag;
    logic [23:0]        mul_a, mul_b;
    logic [47:0]        prod;
    logic [46:0]        d2;
    logic               best_upd;
    logic               emit;
    result_t            res_next;
    logic               sqrt_start, sqrt_done;
    logic [23:0]        sqrt_root;
    logic               div_start, div_done;
    logic [47:0]        div_num, div_quot;
    logic [COORD_W-1:0] dcur, pclamp, new_coord;
    logic               pos_dir;
    logic [8:0]         tag_hit;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Effective node and goal caps
    assign limit = (32'(node_limit_reg) < MAX_NODES) ? LW'(node_limit_reg) : LW'(MAX_NODES);
    assign goals = (32'(goal_count_reg) < MAX_GOALS) ? GCW'(goal_count_reg)
                                                     : GCW'(MAX_GOALS);

    // Grid cell lookup for the point under test
    assign ri32    = 32'(chk_x_reg) >> FRAC_BITS;
    assign ci32    = 32'(chk_y_reg) >> FRAC_BITS;
    assign outside = (ri32 >= 32'(GRID_CELLS)) || (ci32 >= 32'(GRID_CELLS));
    assign grid_ra = AW'((ri32 << 1) | 32'(ci32[6]));
    assign blocked = gvld_q && grid_q[ci32[5:0]];
    assign grid_we = accept && (req.req_type == REQ_OCC)
                     && (32'(req.slot_index) < 32'(GRID_CELLS));
    assign grid_wa = AW'({req.slot_index, req.word_half});

    // Node and goal read addresses run one ahead in the second multiply cycle
    assign nxt_i   = scan_i_reg + SW'(1);
    assign tree_ra = (state_reg == S_SCAN_Y) ? nxt_i[NW-1:0] : scan_i_reg[NW-1:0];
    assign gnext   = gi_reg + GCW'(1);
    assign goal_ra = (state_reg == S_GOAL_Y) ? gnext[GW-1:0] : gi_reg[GW-1:0];

    // Node zero is the root, held in registers
    assign tx   = tzero_q ? root_x_reg : tx_q;
    assign ty   = tzero_q ? root_y_reg : ty_q;
    assign ttag = tzero_q ? 1'b0 : tt_q;

    // Shared multiplier
    assign prod = mul_a * mul_b;
    assign d2   = 47'(prod_reg) + 47'(prod);

    assign best_upd = !cur_tag_reg && (!found_reg || (d2 < best_d_reg));
    assign tag_hit  = 9'(gi_reg) + 9'd1;

    // Steered offset for the axis being divided
    assign pos_dir   = (state_reg == S_DIV_X) ? (px_reg > bx_reg) : (py_reg > by_reg);
    assign dcur      = dxb_reg;
    assign pclamp    = (div_quot > 48'(dcur)) ? dcur : div_quot[COORD_W-1:0];
    assign new_coord = (state_reg == S_DIV_X)
                       ? (pos_dir ? bx_reg + pclamp : bx_reg - pclamp)
                       : (pos_dir ? by_reg + pclamp : by_reg - pclamp);

    rte_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({1'b0, best_d_reg}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    rte_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        res_next   = '0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        mul_a      = 24'(radius_reg);
        mul_b      = 24'(radius_reg);
        div_num    = prod + 48'(s_reg >> 1);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next.status = ST_WRITE_DONE;
                    if (req.req_type == REQ_SAMPLE)
                    begin
                        if (LW'(tree_size_reg) >= limit)
                        begin
                            res_next.status = ST_FULL;
                            emit = 1'b1;
                        end
                        else
                        begin
                            state_next = S_CELL_RD;
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            S_CELL_RD:
            begin
                if (outside)
                begin
                    res_next.status = phase_reg ? ST_STEP_BLOCKED : ST_SAMPLE_BLOCKED;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CELL_CHK;
                end
            end
            S_CELL_CHK:
            begin
                if (blocked)
                begin
                    res_next.status = phase_reg ? ST_STEP_BLOCKED : ST_SAMPLE_BLOCKED;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!phase_reg)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (goals == '0)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    state_next = S_GOAL_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_X;
            end
            S_SCAN_X:
            begin
                mul_a      = 24'(absdiff(tx, px_reg));
                mul_b      = 24'(absdiff(tx, px_reg));
                state_next = S_SCAN_Y;
            end
            S_SCAN_Y:
            begin
                mul_a      = 24'(dy_reg);
                mul_b      = 24'(dy_reg);
                state_next = (nxt_i == tree_size_reg) ? S_POST : S_SCAN_X;
            end
            S_POST:
            begin
                if (!found_reg)
                begin
                    res_next.status = ST_NO_CAND;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = (best_d_reg <= 47'(r2_reg)) ? S_CELL_RD : S_MUL_X;
                end
            end
            S_MUL_X:
            begin
                mul_a      = 24'(radius_reg);
                mul_b      = 24'(absdiff(bx_reg, px_reg));
                div_start  = 1'b1;
                state_next = S_DIV_X;
            end
            S_DIV_X:
            begin
                if (div_done)
                begin
                    state_next = S_MUL_Y;
                end
            end
            S_MUL_Y:
            begin
                mul_a      = 24'(radius_reg);
                mul_b      = 24'(absdiff(by_reg, py_reg));
                div_start  = 1'b1;
                state_next = S_DIV_Y;
            end
            S_DIV_Y:
            begin
                if (div_done)
                begin
                    state_next = S_CELL_RD;
                end
            end
            S_GOAL_RD:
            begin
                state_next = S_GOAL_X;
            end
            S_GOAL_X:
            begin
                mul_a      = 24'(absdiff(gx_q, chk_x_reg));
                mul_b      = 24'(absdiff(gx_q, chk_x_reg));
                state_next = S_GOAL_Y;
            end
            S_GOAL_Y:
            begin
                mul_a = 24'(dy_reg);
                mul_b = 24'(dy_reg);
                if ((d2 < 47'(r2_reg)) || (gnext == goals))
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    state_next = S_GOAL_X;
                end
            end
            S_STORE:
            begin
                res_next.status       = ST_ADDED;
                res_next.node_index   = IDX_W'(tree_size_reg);
                res_next.parent_index = IDX_W'(best_i_reg);
                res_next.node_x       = chk_x_reg;
                res_next.node_y       = chk_y_reg;
                res_next.goal_hit     = tag_reg[TAG_W-1:0];
                res_next.edge_length  = edge_reg;
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            radius_reg       <= RADIUS_RST;
            node_limit_reg   <= LIMIT_W'(1024);
            goal_count_reg   <= '0;
            tree_size_reg    <= SW'(1);
            root_x_reg       <= '0;
            root_y_reg       <= '0;
            grid_vld_reg     <= '0;
            gvld_q           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= emit;
            gvld_q           <= grid_vld_reg[grid_ra];
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X:    origin_x_reg   <= cfg_data;
                    CFG_ORIGIN_Y:    origin_y_reg   <= cfg_data;
                    CFG_STEP_RADIUS: radius_reg     <= cfg_data;
                    CFG_NODE_LIMIT:  node_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_GOAL_COUNT:  goal_count_reg <= cfg_data[4:0];
                    default:         ;
                endcase
            end
            if (accept && (req.req_type == REQ_RESTART))
            begin
                tree_size_reg <= SW'(1);
                root_x_reg    <= origin_x_reg;
                root_y_reg    <= origin_y_reg;
            end
            if (grid_we)
            begin
                grid_vld_reg[grid_wa] <= 1'b1;
            end
            if (state_reg == S_STORE)
            begin
                tree_size_reg <= tree_size_reg + SW'(1);
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= res_next;
        end
        case (state_reg)
            S_IDLE:
            begin
                px_reg    <= req.point_x;
                py_reg    <= req.point_y;
                chk_x_reg <= req.point_x;
                chk_y_reg <= req.point_y;
                phase_reg <= 1'b0;
                r2_reg    <= prod[45:0];
            end
            S_CELL_CHK:
            begin
                scan_i_reg <= '0;
                found_reg  <= 1'b0;
                gi_reg     <= '0;
                tag_reg    <= '0;
            end
            S_SCAN_X:
            begin
                prod_reg    <= prod;
                dy_reg      <= absdiff(ty, py_reg);
                cur_x_reg   <= tx;
                cur_y_reg   <= ty;
                cur_tag_reg <= ttag;
            end
            S_SCAN_Y:
            begin
                if (best_upd)
                begin
                    found_reg  <= 1'b1;
                    best_d_reg <= d2;
                    best_i_reg <= scan_i_reg;
                    bx_reg     <= cur_x_reg;
                    by_reg     <= cur_y_reg;
                end
                scan_i_reg <= nxt_i;
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    s_reg <= sqrt_root;
                    if (best_d_reg <= 47'(r2_reg))
                    begin
                        chk_x_reg <= px_reg;
                        chk_y_reg <= py_reg;
                        edge_reg  <= sqrt_root;
                        phase_reg <= 1'b1;
                    end
                end
            end
            S_MUL_X:
            begin
                dxb_reg <= absdiff(bx_reg, px_reg);
            end
            S_DIV_X:
            begin
                if (div_done)
                begin
                    nx_reg <= new_coord;
                end
            end
            S_MUL_Y:
            begin
                dxb_reg <= absdiff(by_reg, py_reg);
            end
            S_DIV_Y:
            begin
                if (div_done)
                begin
                    chk_x_reg <= nx_reg;
                    chk_y_reg <= new_coord;
                    edge_reg  <= EDGE_W'(radius_reg);
                    phase_reg <= 1'b1;
                end
            end
            S_GOAL_X:
            begin
                prod_reg <= prod;
                dy_reg   <= absdiff(gy_q, chk_y_reg);
            end
            S_GOAL_Y:
            begin
                if (d2 < 47'(r2_reg))
                begin
                    tag_reg <= tag_hit;
                end
                gi_reg <= gnext;
            end
            default:
            begin
            end
        endcase
    end

    // Tree storage: written at the new index, read by the scan
    always_ff @(posedge clk)
    begin
        if (state_reg == S_STORE)
        begin
            tree_x_mem[tree_size_reg[NW-1:0]] <= chk_x_reg;
            tree_y_mem[tree_size_reg[NW-1:0]] <= chk_y_reg;
            tree_t_mem[tree_size_reg[NW-1:0]] <= (tag_reg != '0);
        end
        tx_q    <= tree_x_mem[tree_ra];
        ty_q    <= tree_y_mem[tree_ra];
        tt_q    <= tree_t_mem[tree_ra];
        tzero_q <= (tree_ra == '0);
    end

    // Goal table
    always_ff @(posedge clk)
    begin
        if (accept && (req.req_type == REQ_GOAL) && (32'(req.slot_index) < MAX_GOALS))
        begin
            goal_x_mem[GW'(req.slot_index)] <= req.point_x;
            goal_y_mem[GW'(req.slot_index)] <= req.point_y;
        end
        gx_q <= goal_x_mem[goal_ra];
        gy_q <= goal_y_mem[goal_ra];
    end

    // Occupancy grid words
    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_wa] <= req.occupancy_word;
        end
        grid_q <= grid_mem[grid_ra];
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

// ----- bench/rrt_tree_extend_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, config and result channels of rrt_tree_extend, keeps
// its own copy of the tree, goals and occupancy grid, and checks every result.
module rrt_tree_extend_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          cfg_we,
    input  wire logic [rte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rte_pkg::COORD_W-1:0]   cfg_data,
    input  wire rte_pkg::req_t                 req,
    input  wire rte_pkg::result_t              result,
    input  wire logic                          result_valid,
    output int                                 errors,
    output int                                 outstanding,
    output int                                 results_seen,
    output int                                 nodes_added
);

    import rte_pkg::*;

    localparam int NODES = 1024;
    localparam int GOALS = 16;
    localparam int CELLS = 100;
    localparam int FRAC  = 16;

    // Register copies
    logic [COORD_W-1:0] org_x, org_y, radius;
    logic [LIMIT_W-1:0] limit_reg;
    logic [4:0]         goals_used;

    // Tree, goal table and grid copies
    logic [COORD_W-1:0] tree_px [0:NODES-1];
    logic [COORD_W-1:0] tree_py [0:NODES-1];
    logic [TAG_W-1:0]   tree_tag [0:NODES-1];
    int unsigned        tree_count;
    logic [COORD_W-1:0] goal_px [0:GOALS-1];
    logic [COORD_W-1:0] goal_py [0:GOALS-1];
    logic [63:0]        occ_words [0:2*CELLS-1];

    result_t expected_q [$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] sq_dist(input logic [COORD_W-1:0] ax, ay, bx, by);
        logic [63:0] dx, dy;
        dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
        dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
        return dx * dx + dy * dy;
    endfunction

    function automatic logic cell_blocked(input logic [COORD_W-1:0] x, y);
        int unsigned row, col;
        row = x >> FRAC;
        col = y >> FRAC;
        if (row >= CELLS || col >= CELLS) return 1'b1;
        return occ_words[2 * row + col / 64][col % 64];
    endfunction

    // Move from 'from' toward 'to' by the radius share of the axis offset
    function automatic logic [COORD_W-1:0] steer_axis(input logic [COORD_W-1:0] from, to,
                                                      input logic [63:0] rr, s);
        logic [63:0] d, p;
        d = (to > from) ? 64'(to - from) : 64'(from - to);
        p = (rr * d + s / 2) / s;
        if (p > d) p = d;
        return (to > from) ? from + COORD_W'(p) : from - COORD_W'(p);
    endfunction

    function automatic void restart_tree();
        tree_px[0]  = org_x;
        tree_py[0]  = org_y;
        tree_tag[0] = '0;
        tree_count  = 1;
    endfunction

    // Expected result of one request; updates the state copies
    function automatic result_t extend_tree(input req_t r);
        result_t     res;
        logic [63:0] d2, best_d, r2, s, rr;
        int unsigned lim, i, best, ng;
        logic        found;
        logic [COORD_W-1:0] nx, ny;
        logic [TAG_W-1:0]   tag;
        logic [EDGE_W-1:0]  step_len;
        res        = '0;
        res.status = ST_WRITE_DONE;
        found      = 1'b0;
        best       = 0;
        best_d     = '0;
        tag        = '0;
        rr         = 64'(radius);
        r2         = rr * rr;
        case (r.req_type)
            REQ_RESTART: restart_tree();
            REQ_GOAL: begin
                if (r.slot_index < GOALS) begin
                    goal_px[r.slot_index] = r.point_x;
                    goal_py[r.slot_index] = r.point_y;
                end
            end
            REQ_OCC: begin
                if (r.slot_index < CELLS)
                    occ_words[2 * r.slot_index + r.word_half] = r.occupancy_word;
            end
            default: begin
                lim = (limit_reg < NODES) ? limit_reg : NODES;
                if (tree_count >= lim) begin
                    res.status = ST_FULL;
                    return res;
                end
                if (cell_blocked(r.point_x, r.point_y)) begin
                    res.status = ST_SAMPLE_BLOCKED;
                    return res;
                end
                // nearest untagged node, lowest index on ties
                for (i = 0; i < tree_count; i++) begin
                    if (tree_tag[i] != 0) continue;
                    d2 = sq_dist(tree_px[i], tree_py[i], r.point_x, r.point_y);
                    if (!found || d2 < best_d) begin
                        found  = 1'b1;
                        best_d = d2;
                        best   = i;
                    end
                end
                if (!found) begin
                    res.status = ST_NO_CAND;
                    return res;
                end
                if (best_d <= r2) begin
                    nx       = r.point_x;
                    ny       = r.point_y;
                    step_len = EDGE_W'(int_sqrt(best_d));
                end
                else begin
                    s        = int_sqrt(best_d);
                    nx       = steer_axis(tree_px[best], r.point_x, rr, s);
                    ny       = steer_axis(tree_py[best], r.point_y, rr, s);
                    step_len = EDGE_W'(radius);
                end
                if (cell_blocked(nx, ny)) begin
                    res.status = ST_STEP_BLOCKED;
                    return res;
                end
                ng = (goals_used < GOALS) ? goals_used : GOALS;
                for (i = 0; i < ng; i++) begin
                    if (sq_dist(goal_px[i], goal_py[i], nx, ny) < r2) begin
                        tag = TAG_W'(i + 1);
                        break;
                    end
                end
                tree_px[tree_count]  = nx;
                tree_py[tree_count]  = ny;
                tree_tag[tree_count] = tag;
                res.status       = ST_ADDED;
                res.node_index   = IDX_W'(tree_count);
                res.parent_index = IDX_W'(best);
                res.node_x       = nx;
                res.node_y       = ny;
                res.goal_hit     = tag;
                res.edge_length  = step_len;
                tree_count       = tree_count + 1;
            end
        endcase
        return res;
    endfunction

    // Result check, register writes and request capture
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp;
        result_t pred;
        if (!rst_n) begin
            org_x      = '0;
            org_y      = '0;
            radius     = COORD_W'(5 << FRAC);
            limit_reg  = LIMIT_W'(NODES);
            goals_used = '0;
            for (int k = 0; k < 2 * CELLS; k++) occ_words[k] = '0;
            for (int k = 0; k < GOALS; k++) begin
                goal_px[k] = '0;
                goal_py[k] = '0;
            end
            restart_tree();
            expected_q.delete();
            errors       = 0;
            outstanding  = 0;
            results_seen = 0;
            nodes_added  = 0;
        end
        else begin
            if (result_valid) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: got %p", $time, result);
                end
                else begin
                    exp = expected_q.pop_front();
                    if (result !== exp) begin
                        errors++;
                        $display("%0t: result mismatch: expected %p got %p", $time, exp, result);
                    end
                    else if (exp.status == ST_ADDED) begin
                        nodes_added++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ORIGIN_X:    org_x = cfg_data;
                    CFG_ORIGIN_Y:    org_y = cfg_data;
                    CFG_STEP_RADIUS: radius = cfg_data;
                    CFG_NODE_LIMIT:  limit_reg = cfg_data[LIMIT_W-1:0];
                    CFG_GOAL_COUNT:  goals_used = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                pred       = extend_tree(req);
                expected_q = {expected_q, pred};
            end
            outstanding = expected_q.size();
        end
    end

endmodule

// ----- bench/rrt_tree_extend_tb.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for rrt_tree_extend; checking is in the checker module.
module rrt_tree_extend_tb;
    import rte_pkg::*;

    localparam int  MAX_COORD = 6553599;
    localparam int  SPREAD    = 12 << 16;
    localparam int  PHASES    = 6;
    localparam int  PER_PHASE = 85;
    localparam longint LIMIT  = 5000000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    req_t    req;
    result_t result;
    logic    result_valid;

    int errors, outstanding, results_seen, nodes_added;
    int idle_pct;
    int cur_ox, cur_oy;
    longint cycles;

    // Per-phase register settings
    int org_x_tab [PHASES]  = '{0, MAX_COORD, 2000000, 3276800, 0, 0};
    int org_y_tab [PHASES]  = '{0, MAX_COORD, 4000000, 0, 1000000, MAX_COORD};
    int radius_tab [PHASES] = '{327680, 1310720, MAX_COORD, 1, 196608, 500000};
    int limit_tab [PHASES]  = '{1024, 1, 40, 64, 1024, 32};
    int goals_tab [PHASES]  = '{16, 0, 5, 16, 3, 8};

    rrt_tree_extend dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .result      (result),
        .result_valid(result_valid)
    );

    rrt_tree_extend_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .result      (result),
        .result_valid(result_valid),
        .errors      (errors),
        .outstanding (outstanding),
        .results_seen(results_seen),
        .nodes_added (nodes_added)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("rrt_tree_extend_tb: done, errors");
            $finish;
        end
    end

    function automatic req_t make_req(input logic [1:0] kind, input int x, y, slot,
                                      input bit half, input logic [63:0] word);
        req_t r;
        r.req_type       = kind;
        r.point_x        = COORD_W'(x);
        r.point_y        = COORD_W'(y);
        r.slot_index     = 7'(slot);
        r.word_half      = half;
        r.occupancy_word = word;
        return r;
    endfunction

    function automatic int near_coord(input int base);
        int v;
        v = base + int'($urandom_range(0, 2 * SPREAD)) - SPREAD;
        if (v < 0) v = 0;
        if (v > MAX_COORD) v = MAX_COORD;
        return v;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send(input req_t r);
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        req   = r;
        do @(posedge clk); while (busy);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = COORD_W'(val);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic wait_idle();
        while (outstanding != 0 || busy) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic req_t random_req();
        int pick, x, y;
        logic [63:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return make_req(REQ_RESTART, $urandom, $urandom, $urandom, $urandom, rand_word());
        if (pick < 8)
            return make_req(REQ_GOAL, near_coord(cur_ox), near_coord(cur_oy),
                            $urandom_range(0, 20), $urandom, rand_word());
        if (pick < 16) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: w = '0;
                4:          w = '1;
                default:    w = rand_word() & rand_word() & rand_word() & rand_word();
            endcase
            return make_req(REQ_OCC, $urandom, $urandom, $urandom_range(0, 127),
                            $urandom, w);
        end
        if ($urandom_range(0, 3) == 0) begin
            x = $urandom_range(0, MAX_COORD);
            y = $urandom_range(0, MAX_COORD);
        end
        else begin
            x = near_coord(cur_ox);
            y = near_coord(cur_oy);
        end
        return make_req(REQ_SAMPLE, x, y, $urandom, $urandom, rand_word());
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        req       = '0;
        idle_pct  = 27;
        cur_ox    = 0;
        cur_oy    = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: goal table load, bad indexes, blocked cases, extremes
        send(make_req(REQ_GOAL, 1 << 16, 1 << 16, 0, 0, '0));
        send(make_req(REQ_GOAL, MAX_COORD, MAX_COORD, 1, 0, '0));
        for (int k = 2; k < 16; k++)
            send(make_req(REQ_GOAL, $urandom_range(0, MAX_COORD),
                          $urandom_range(0, MAX_COORD), k, 0, '0));
        send(make_req(REQ_GOAL, 0, 0, 127, 1, '1));
        send(make_req(REQ_OCC, 0, 0, 127, 1, '1));
        send(make_req(REQ_OCC, 0, 0, 0, 0, 64'd1));
        send(make_req(REQ_SAMPLE, 32768, 32768, 0, 0, '0));
        send(make_req(REQ_OCC, 0, 0, 0, 0, '0));
        send(make_req(REQ_OCC, 0, 0, 5, 1, '1));
        send(make_req(REQ_SAMPLE, 5 << 16, 80 << 16, 0, 0, '0));
        send(make_req(REQ_OCC, 0, 0, 3, 0, 64'd1 << 3));
        send(make_req(REQ_SAMPLE, 50 << 16, 50 << 16, 0, 0, '0));
        send(make_req(REQ_OCC, 0, 0, 3, 0, '0));
        send(make_req(REQ_SAMPLE, 32'h7FFFFF, 32'h7FFFFF, 0, 0, '0));
        send(make_req(REQ_SAMPLE, 0, 0, 0, 0, '0));
        send(make_req(REQ_SAMPLE, MAX_COORD, MAX_COORD, 0, 0, '0));
        send(make_req(REQ_RESTART, 0, 0, 0, 0, '0));

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            idle_pct = (p < 2) ? 27 : (p < 4) ? 79 : 0;
            wait_idle();
            write_reg(CFG_ORIGIN_X, org_x_tab[p]);
            write_reg(CFG_ORIGIN_Y, org_y_tab[p]);
            write_reg(CFG_STEP_RADIUS, radius_tab[p]);
            write_reg(CFG_NODE_LIMIT, limit_tab[p]);
            write_reg(CFG_GOAL_COUNT, goals_tab[p]);
            cur_ox = org_x_tab[p];
            cur_oy = org_y_tab[p];
            send(make_req(REQ_RESTART, 0, 0, 0, 0, '0));
            for (int n = 0; n < PER_PHASE; n++) send(random_req());
        end

        wait_idle();
        repeat (40) @(negedge clk);
        $display("Run covered %0d results, %0d nodes added, over %0d register settings",
                 results_seen, nodes_added, PHASES);
        $display("with sender idling at 27, 79 and 0 percent.");
        if (errors == 0) begin
            $display("rrt_tree_extend_tb: done, clean");
        end
        else begin
            $display("rrt_tree_extend_tb: done, errors");
        end
        $finish;
    end

endmodule
